// ----- hdl/i2cm_pkg.sv -----
// Shared types, command codes and phase tables for the I2C master bit engine.
// No dependencies; used by i2cm_phase_dec and i2c_master_bit_engine_core.
`default_nettype none

package i2cm_pkg;

  localparam int PhaseTicksW = 16;
  localparam int PhaseW      = 5;
  localparam int ByteW       = 8;
  localparam int CmdW        = 3;
  localparam int InDataW     = 16;
  localparam int InUserW     = 4;
  localparam int OutDataW    = 16;

  localparam logic [PhaseTicksW-1:0] PhaseTicksReset = 16'd5;

  localparam logic [CmdW-1:0] CMD_START   = 3'd0;
  localparam logic [CmdW-1:0] CMD_STOP    = 3'd1;
  localparam logic [CmdW-1:0] CMD_WRITE   = 3'd2;
  localparam logic [CmdW-1:0] CMD_READ    = 3'd3;
  localparam logic [CmdW-1:0] CMD_WAITACK = 3'd4;
  localparam logic [CmdW-1:0] CMD_MACK    = 3'd5;
  localparam logic [CmdW-1:0] CMD_IDLE    = 3'd7;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [PhaseW-1:0] phase;
    logic [ByteW-1:0]  shift;
    logic              scl_hold;
    logic              sda_hold;
  } phase_ctx_t;

  typedef struct packed {
    logic scl;
    logic sda;
  } pins_t;

  function automatic logic [PhaseW-1:0] phase_total(input logic [CmdW-1:0] cmd);
    logic [PhaseW-1:0] total;
    case (cmd)
      CMD_WRITE: total = 5'd24;
      CMD_READ:  total = 5'd16;
      default:   total = 5'd3;
    endcase
    return total;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/i2c_master_bit_engine_core.sv -----
// Top level of the I2C master bit engine: tick handshake, phase timing and state.
// Depends on i2cm_pkg and i2cm_phase_dec.
//
// Usage: every beat on the in_ channel is one tick of the time base. On a tick
// with cmd_valid set while the engine is idle, the beat also starts a command
// (start, stop, write byte, read byte, wait ack, master ack); commands given
// while busy, and codes 6 and 7, are dropped. Each pin phase lasts phase_ticks
// ticks (zero counts as one), set through the cfg_ port while idle.
// Every input beat produces exactly one out_ beat with the SCL/SDA levels of
// that tick, busy, a done pulse, the last read byte and the last ack flag.
// A result beat appears in the cycle after its input beat, and one beat per cycle
// is sustained while out_tready is high; the single result register holds the
// tick state update. When out_tready is low the result register holds its beat
// and in_tready drops, so no tick is taken until the result is drained.
// Reset (rst_n low, synchronous) returns the engine to idle with both lines
// released, clears the read byte and ack flag, and sets phase_ticks to five.
`default_nettype none

module i2c_master_bit_engine_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] tx_byte, [8] give_ack, [9] sda_in, [15:10] zero
  input  logic [i2cm_pkg::InDataW-1:0]   in_tdata,
  // [0] cmd_valid, [3:1] mode
  input  logic [i2cm_pkg::InUserW-1:0]   in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte,
  // [12] ack_seen, [15:13] zero
  output logic [i2cm_pkg::OutDataW-1:0]  out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [i2cm_pkg::PhaseTicksW-1:0] cfg_data
);
  import i2cm_pkg::*;

  logic [PhaseTicksW-1:0] ptick_r;
  logic [CmdW-1:0]        cmd_r, cmd_nxt;
  logic [PhaseW-1:0]      phase_r, phase_nxt;
  logic [PhaseTicksW-1:0] tick_r, tick_nxt;
  logic [ByteW-1:0]       shift_r, shift_nxt;
  logic [ByteW-1:0]       rxb_r, rxb_nxt;
  logic                   scl_r, sda_r, ack_r, ack_nxt;
  logic                   out_valid_r;
  logic [OutDataW-1:0]    out_data_r, out_data_nxt;

  logic                   cmd_valid, give_ack, sda_in;
  logic [CmdW-1:0]        mode;
  logic [ByteW-1:0]       tx_byte;
  logic                   in_acc, start_cmd, active, wrap, last_phase, done;
  logic [CmdW-1:0]        cmd_a;
  logic [PhaseW-1:0]      phase_a, phase_inc;
  logic [PhaseTicksW-1:0] tick_a, tick_inc, limit;
  logic [ByteW-1:0]       shift_a;
  phase_ctx_t             ctx;
  pins_t                  pins;

  assign cmd_valid = in_tuser[0];
  assign mode      = in_tuser[3:1];
  assign tx_byte   = in_tdata[7:0];
  assign give_ack  = in_tdata[8];
  assign sda_in    = in_tdata[9];

  assign in_tready = ~out_valid_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  assign start_cmd = (cmd_r == CMD_IDLE) & cmd_valid & (mode <= CMD_MACK);
  assign cmd_a     = start_cmd ? mode : cmd_r;
  assign phase_a   = start_cmd ? '0 : phase_r;
  assign tick_a    = start_cmd ? '0 : tick_r;

  always_comb begin
    shift_a = shift_r;
    if (start_cmd) begin
      case (mode)
        CMD_WRITE: shift_a = tx_byte;
        CMD_MACK:  shift_a = {{(ByteW-1){1'b0}}, give_ack};
        default:   shift_a = '0;
      endcase
    end
  end

  assign active = (cmd_a != CMD_IDLE);

  assign ctx.cmd      = cmd_a;
  assign ctx.phase    = phase_a;
  assign ctx.shift    = shift_a;
  assign ctx.scl_hold = scl_r;
  assign ctx.sda_hold = sda_r;

  i2cm_phase_dec u_dec (
    .ctx  (ctx),
    .pins (pins)
  );

  assign limit      = (ptick_r == '0) ? PhaseTicksW'(1) : ptick_r;
  assign tick_inc   = tick_a + PhaseTicksW'(1);
  assign wrap       = (tick_inc >= limit);
  assign phase_inc  = phase_a + PhaseW'(1);
  assign last_phase = (phase_inc >= phase_total(cmd_a));

  always_comb begin
    cmd_nxt   = cmd_a;
    phase_nxt = phase_a;
    tick_nxt  = tick_a;
    shift_nxt = shift_a;
    rxb_nxt   = rxb_r;
    ack_nxt   = ack_r;
    done      = 1'b0;
    if (active) begin
      tick_nxt = wrap ? '0 : tick_inc;
      if (wrap) begin
        if ((cmd_a == CMD_READ) && !phase_a[0]) begin
          shift_nxt = {shift_a[ByteW-2:0], sda_in};
        end
        if ((cmd_a == CMD_WAITACK) && (phase_a == 5'd1)) begin
          ack_nxt = ~sda_in;
        end
        phase_nxt = phase_inc;
        if (last_phase) begin
          if (cmd_a == CMD_READ) begin
            rxb_nxt = shift_nxt;
          end
          cmd_nxt   = CMD_IDLE;
          phase_nxt = '0;
          done      = 1'b1;
        end
      end
    end
  end

  assign out_data_nxt = {3'b000, ack_nxt, rxb_nxt, done,
                         (cmd_nxt != CMD_IDLE), pins.sda, pins.scl};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptick_r     <= PhaseTicksReset;
      cmd_r       <= CMD_IDLE;
      phase_r     <= '0;
      tick_r      <= '0;
      shift_r     <= '0;
      rxb_r       <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ptick_r <= cfg_data;
      end
      if (in_acc) begin
        cmd_r       <= cmd_nxt;
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        shift_r     <= shift_nxt;
        rxb_r       <= rxb_nxt;
        scl_r       <= pins.scl;
        sda_r       <= pins.sda;
        ack_r       <= ack_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A finished command never reports itself as still busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[3]) |-> !out_tdata[2])
    else $error("done pulse with busy set");

  // An idle engine always restarts from the first phase.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r == CMD_IDLE) |-> (phase_r == '0))
    else $error("idle engine with nonzero phase");

  // The tick counter stays inside the current phase length.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r != CMD_IDLE) |-> (tick_r < limit))
    else $error("tick counter beyond phase length");

  // The phase index stays inside the active command's phase list.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r != CMD_IDLE) |-> (phase_r < phase_total(cmd_r)))
    else $error("phase index beyond command length");

  // A stalled result blocks new ticks.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_tready)
    else $error("tick taken while result is stalled");

endmodule

`default_nettype wire

// ----- hdl/i2cm_phase_dec.sv -----
// Pin level decoder: maps the active command, phase and shift byte to SCL/SDA.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_phase_dec (
  input  i2cm_pkg::phase_ctx_t ctx,
  output i2cm_pkg::pins_t      pins
);
  import i2cm_pkg::*;

  logic [9:0]        p_x11;
  logic [3:0]        bit_q;
  logic [PhaseW-1:0] sub_r3;
  logic [2:0]        bit_sel;

  // Division by three through multiply by 11/32, exact for phases below 32.
  assign p_x11   = {5'b0, ctx.phase} * 10'd11;
  assign bit_q   = p_x11[8:5];
  assign sub_r3  = ctx.phase - PhaseW'({1'b0, bit_q} * 5'd3);
  assign bit_sel = 3'd7 - bit_q[2:0];

  always_comb begin
    pins.scl = ctx.scl_hold;
    pins.sda = ctx.sda_hold;
    case (ctx.cmd)
      CMD_START: begin
        pins.scl = (ctx.phase < 5'd2);
        pins.sda = (ctx.phase == 5'd0);
      end
      CMD_STOP: begin
        pins.scl = (ctx.phase != 5'd0);
        pins.sda = (ctx.phase == 5'd2);
      end
      CMD_WRITE: begin
        pins.scl = (sub_r3 == 5'd1);
        pins.sda = ctx.shift[bit_sel];
      end
      CMD_READ: begin
        pins.scl = ~ctx.phase[0];
        pins.sda = 1'b1;
      end
      CMD_WAITACK: begin
        if (ctx.phase == 5'd1) begin
          pins.scl = 1'b1;
        end else if (ctx.phase == 5'd2) begin
          pins.scl = 1'b0;
        end
        pins.sda = 1'b1;
      end
      CMD_MACK: begin
        pins.scl = (ctx.phase == 5'd1);
        pins.sda = ~ctx.shift[0];
      end
      default: begin
        pins.scl = ctx.scl_hold;
        pins.sda = ctx.sda_hold;
      end
    endcase
  end

endmodule

`default_nettype wire
